@@ rtl/core/crv_pkg.sv @@
// Shared constants and template lookup for the catalog record validator.
package crv_pkg;

  localparam int COL_W = 8;

  localparam logic [COL_W-1:0] REC_LEN     = COL_W'(132);
  localparam logic [COL_W-1:0] DECAY_START = COL_W'(75);
  localparam logic [COL_W-1:0] DECAY_END   = COL_W'(84);
  localparam logic [COL_W-1:0] CROSS_START = COL_W'(119);
  localparam logic [COL_W-1:0] CROSS_END   = COL_W'(126);

  localparam int TMPL_LEN = 132;
  localparam int NA_LEN   = 8;

  localparam logic [8*TMPL_LEN-1:0] TMPL =
    {"nnnn-nnnaaa  nnnnn M*O aaaaaaaaaaaaaaaaaaaaaaaa  aaaaa  nnnn-nn-nn  aaaaa  ",
     "lnnn-nn-nn  NNNNn.n  NNn.n  NNNNNn  NNNNNn  LNn.nnnn  aaa"};

  localparam logic [8*NA_LEN-1:0] NA_TEXT = "   N/A  ";

  // template column classes
  localparam logic [7:0] T_DIGIT      = "n";
  localparam logic [7:0] T_LEAD_DIGIT = "l";
  localparam logic [7:0] T_PRINT      = "a";
  localparam logic [7:0] T_FLAG_M     = "M";
  localparam logic [7:0] T_FLAG_STAR  = "*";
  localparam logic [7:0] T_STATUS     = "O";
  localparam logic [7:0] T_NUM        = "N";
  localparam logic [7:0] T_NUM_LEAD   = "L";

  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_NUL   = 8'h00;

  function automatic logic [7:0] tmpl_char(input logic [COL_W-1:0] pos);
    int idx;
    idx = TMPL_LEN - 1 - int'(pos);
    if (pos >= REC_LEN) begin
      return 8'h00;
    end
    return TMPL[idx*8 +: 8];
  endfunction

  function automatic logic [7:0] na_char(input logic [COL_W-1:0] pos);
    logic [2:0] off;
    off = 3'(pos - CROSS_START);
    return NA_TEXT[(3'(NA_LEN - 1) - off)*8 +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_status(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "P") || (c == "B") || (c == "S") ||
           (c == "X") || (c == "D") || (c == "?") || (c == CH_SPACE);
  endfunction

endpackage

@@ rtl/core/crv_col_check.sv @@
// Per-column check of one byte against the record template.
module crv_col_check (
  input  logic [crv_pkg::COL_W-1:0] pos,
  input  logic [7:0]                ch,
  input  logic                      prior_nonspace,
  output logic                      ok
);

  logic [7:0] t;
  logic [7:0] prev_t;

  assign t      = crv_pkg::tmpl_char(pos);
  assign prev_t = (pos == '0) ? 8'h00 : crv_pkg::tmpl_char(pos - 1'b1);

  always_comb begin
    ok = 1'b0;
    if (ch != crv_pkg::CH_NUL) begin
      unique case (t)
        crv_pkg::T_DIGIT, crv_pkg::T_LEAD_DIGIT: ok = crv_pkg::is_digit(ch);
        crv_pkg::T_PRINT:     ok = (ch >= 8'h20) && (ch <= 8'h7E);
        crv_pkg::T_FLAG_M, crv_pkg::T_FLAG_STAR:
                              ok = (ch == crv_pkg::CH_SPACE) || (ch == t);
        crv_pkg::T_STATUS:    ok = crv_pkg::is_status(ch);
        crv_pkg::T_NUM, crv_pkg::T_NUM_LEAD: begin
          // right-justified field: no space directly after a non-space in an N column
          if (prev_t == crv_pkg::T_NUM && prior_nonspace && ch == crv_pkg::CH_SPACE) begin
            ok = 1'b0;
          end else begin
            ok = (ch == crv_pkg::CH_SPACE) || crv_pkg::is_digit(ch);
          end
        end
        default:              ok = (ch == t);
      endcase
    end
  end

endmodule

@@ rtl/core/catalog_record_validator.sv @@
// Top level of the catalog record validator.
// Usage:
//   Input channel (in_valid / in_stall, in_ch, in_last) carries one record
//   byte per beat; in_last marks the final byte of a record. Records are
//   checked column by column against the fixed 132-column template.
//   Output channel (out_valid / out_stall, out_valid_res) carries one beat
//   per record, on the byte marked last: 1 if the record matched.
// Throughput: one byte per cycle unless in_stall holds the input; the check is two
//   template lookups and a few compares between the input register and the state registers.
// Result: out_valid rises once the last byte's beat has passed through the input
//   register and has loaded the result register.
// Stall: while a result waits under out_stall, non-final bytes keep flowing;
//   a further final byte holds in the input register and in_stall is raised
//   until the result register frees.
// Reset: rst_n low clears both registers' valid flags and the record state
//   (column count zero, all checks passing). Bytes after column 131 are
//   ignored; a NUL byte or a record shorter than 132 bytes reads as invalid.
module catalog_record_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res
);

  logic                      s1_v_r;
  logic [7:0]                s1_ch_r;
  logic                      s1_last_r;
  logic                      s1_adv;
  logic                      s1_fire;

  logic [crv_pkg::COL_W-1:0] col_r, col_nxt;
  logic                      all_ok_r, all_ok_nxt;
  logic                      dblank_r, dblank_nxt;
  logic                      ddig_r, ddig_nxt;
  logic                      na_r, na_nxt;
  logic                      xdig_r, xdig_nxt;
  logic                      pns_r, pns_nxt;

  logic                      out_v_r, out_v_nxt;
  logic                      res_r, res_nxt;

  logic                      ok;
  logic                      in_rec;
  logic                      is_space;

  // a non-final byte never needs the result register
  assign s1_adv   = !s1_last_r || !out_v_r || !out_stall;
  assign s1_fire  = s1_v_r && s1_adv;
  assign in_stall = s1_v_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  crv_col_check u_col_check (
    .pos            (col_r),
    .ch             (s1_ch_r),
    .prior_nonspace (pns_r),
    .ok             (ok)
  );

  assign in_rec   = col_r < crv_pkg::REC_LEN;
  assign is_space = s1_ch_r == crv_pkg::CH_SPACE;

  always_comb begin
    col_nxt    = col_r;
    all_ok_nxt = all_ok_r;
    dblank_nxt = dblank_r;
    ddig_nxt   = ddig_r;
    na_nxt     = na_r;
    xdig_nxt   = xdig_r;
    pns_nxt    = pns_r;
    out_v_nxt  = out_v_r && out_stall;
    res_nxt    = res_r;
    if (s1_fire) begin
      if (in_rec) begin
        if (col_r >= crv_pkg::DECAY_START && col_r <= crv_pkg::DECAY_END) begin
          dblank_nxt = dblank_r && is_space;
          ddig_nxt   = ddig_r && ok;
          if (col_r == crv_pkg::DECAY_END) begin
            all_ok_nxt = all_ok_r && (dblank_nxt || ddig_nxt);
          end
        end else if (col_r >= crv_pkg::CROSS_START && col_r <= crv_pkg::CROSS_END) begin
          na_nxt   = na_r && (s1_ch_r == crv_pkg::na_char(col_r));
          xdig_nxt = xdig_r && ok;
          if (col_r == crv_pkg::CROSS_END) begin
            all_ok_nxt = all_ok_r && (na_nxt || xdig_nxt);
          end
        end else begin
          all_ok_nxt = all_ok_r && ok;
        end
        pns_nxt = !is_space;
        col_nxt = col_r + 1'b1;
      end
      if (s1_last_r) begin
        out_v_nxt  = 1'b1;
        res_nxt    = all_ok_nxt && (col_nxt >= crv_pkg::REC_LEN);
        col_nxt    = '0;
        all_ok_nxt = 1'b1;
        dblank_nxt = 1'b1;
        ddig_nxt   = 1'b1;
        na_nxt     = 1'b1;
        xdig_nxt   = 1'b1;
        pns_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      all_ok_r <= 1'b1;
      dblank_r <= 1'b1;
      ddig_r   <= 1'b1;
      na_r     <= 1'b1;
      xdig_r   <= 1'b1;
      pns_r    <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      all_ok_r <= all_ok_nxt;
      dblank_r <= dblank_nxt;
      ddig_r   <= ddig_nxt;
      na_r     <= na_nxt;
      xdig_r   <= xdig_nxt;
      pns_r    <= pns_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_valid_res = res_r;

endmodule
